// ===== rtl/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths, defaults, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  // Fixed field widths of the streams
  localparam int VA_W        = 16;
  localparam int PA_W        = 16;
  localparam int FRAME_OUT_W = 8;
  localparam int COUNT_W     = 32;
  localparam int OUT_TDATA_W = 120;
  localparam int OUT_TUSER_W = 2;

  // Default geometry
  localparam int TLB_ENTRIES_DEF = 16;
  localparam int OFFSET_BITS_DEF = 8;
  localparam int PAGE_BITS_DEF   = 8;

  // Controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SELECT,
    ST_UPDATE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clear_wr;  // write one page-table present bit to zero
    logic accept;    // capture the incoming address
    logic lookup;    // compare TLB tags, read the page table
    logic select;    // pick the matching slot, read its frame
    logic commit;    // update state and load the result
  } tlbpt_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clear_last;  // clearing pass is at its final entry
    logic out_free;    // output register can take a result this cycle
  } tlbpt_status_t;

endpackage

// ===== rtl/tlbpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlbpt_ctrl
// Sequencer: clearing pass after reset, then accept, lookup, select and
// update for each address transaction.
// ----------------------------------------------------------------------------
module tlbpt_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  tlbpt_pkg::tlbpt_status_t status,
  output tlbpt_pkg::tlbpt_cmd_t    cmd
);

  tlbpt_pkg::state_t state;
  tlbpt_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbpt_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tlbpt_pkg::ST_CLEAR: begin
        if (status.clear_last) state_next = tlbpt_pkg::ST_IDLE;
      end
      tlbpt_pkg::ST_IDLE: begin
        if (s_tvalid) state_next = tlbpt_pkg::ST_LOOKUP;
      end
      tlbpt_pkg::ST_LOOKUP: state_next = tlbpt_pkg::ST_SELECT;
      tlbpt_pkg::ST_SELECT: state_next = tlbpt_pkg::ST_UPDATE;
      tlbpt_pkg::ST_UPDATE: begin
        if (status.out_free) state_next = tlbpt_pkg::ST_IDLE;
      end
      default: state_next = tlbpt_pkg::ST_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      tlbpt_pkg::ST_CLEAR:  cmd.clear_wr = 1'b1;
      tlbpt_pkg::ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      tlbpt_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
      tlbpt_pkg::ST_SELECT: cmd.select = 1'b1;
      tlbpt_pkg::ST_UPDATE: cmd.commit = status.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/tlbpt_datapath.sv =====
// ----------------------------------------------------------------------------
// tlbpt_datapath
// TLB tags and valid bits, TLB frame memory, page table memories, FIFO
// pointer, frame allocator, saturating counters and the output register.
// ----------------------------------------------------------------------------
module tlbpt_datapath #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF,
  parameter int PAGE_BITS   = tlbpt_pkg::PAGE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tlbpt_pkg::tlbpt_cmd_t              cmd,
  output tlbpt_pkg::tlbpt_status_t           status,
  input  logic [tlbpt_pkg::VA_W-1:0]         s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tlbpt_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic [tlbpt_pkg::OUT_TUSER_W-1:0]  m_tuser
);

  localparam int NUM_PAGES = 1 << PAGE_BITS;
  localparam int IDX_W     = $clog2(TLB_ENTRIES);
  localparam int NFF_W     = PAGE_BITS + 1;
  localparam int CW        = tlbpt_pkg::COUNT_W;

  // Captured address and its parts
  logic [tlbpt_pkg::VA_W-1:0] va_reg;
  logic [CW-1:0]              va_shift;
  logic [PAGE_BITS-1:0]       page;
  logic [OFFSET_BITS-1:0]     offset;

  // TLB
  logic [TLB_ENTRIES-1:0] tlb_valid;
  logic [PAGE_BITS-1:0]   tlb_page [TLB_ENTRIES];
  logic [PAGE_BITS-1:0]   tlb_frame_mem [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] match_vec;
  logic [TLB_ENTRIES-1:0] match_reg;
  logic [IDX_W-1:0]       sel_idx;
  logic [PAGE_BITS-1:0]   tlb_frame_rd;
  logic                   hit_reg;

  // Page table
  logic                 present_mem [NUM_PAGES];
  logic [PAGE_BITS-1:0] frame_mem [NUM_PAGES];
  logic                 present_rd;
  logic [PAGE_BITS-1:0] pf_rd;
  logic [PAGE_BITS-1:0] clear_addr;
  logic                 pt_we;
  logic [PAGE_BITS-1:0] pt_waddr;
  logic                 pt_wdata;

  // Allocation and counters
  logic [IDX_W-1:0]     fifo_ptr;
  logic [NFF_W-1:0]     next_free;
  logic [PAGE_BITS-1:0] new_frame;
  logic [CW-1:0]        fault_counter;
  logic [CW-1:0]        hit_counter;
  logic [CW-1:0]        reference_counter;

  // Result
  logic                       fault;
  logic                       do_fault;
  logic [PAGE_BITS-1:0]       frame;
  logic [CW-1:0]              phys_wide;
  logic [CW-1:0]              frame_wide;
  logic [tlbpt_pkg::PA_W-1:0] out_phys;
  logic [tlbpt_pkg::FRAME_OUT_W-1:0] out_frame;
  logic                       out_hit;
  logic                       out_fault;
  logic                       out_valid;

  // Split the address
  always_ff @(posedge clk) begin
    if (cmd.accept) va_reg <= s_tdata;
  end

  assign va_shift = CW'(va_reg) >> OFFSET_BITS;
  assign page     = va_shift[PAGE_BITS-1:0];
  assign offset   = va_reg[OFFSET_BITS-1:0];

  // Compare every TLB tag against the page
  always_comb begin
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      match_vec[k] = tlb_valid[k] && (tlb_page[k] == page);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) match_reg <= match_vec;
  end

  // Lowest matching slot wins
  always_comb begin
    sel_idx = '0;
    for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
      if (match_reg[k]) sel_idx = IDX_W'(k);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.select) hit_reg <= |match_reg;
  end

  // TLB frame memory
  always_ff @(posedge clk) begin
    if (do_fault) tlb_frame_mem[fifo_ptr] <= new_frame;
    if (cmd.select) tlb_frame_rd <= tlb_frame_mem[sel_idx];
  end

  // TLB tags and valid bits
  always_ff @(posedge clk) begin
    if (do_fault) tlb_page[fifo_ptr] <= page;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tlb_valid <= '0;
    end else if (do_fault) begin
      tlb_valid[fifo_ptr] <= 1'b1;
    end
  end

  // Page table write port: clearing pass or fault
  assign pt_we    = cmd.clear_wr || do_fault;
  assign pt_waddr = cmd.clear_wr ? clear_addr : page;
  assign pt_wdata = !cmd.clear_wr;

  always_ff @(posedge clk) begin
    if (pt_we) present_mem[pt_waddr] <= pt_wdata;
    if (cmd.lookup) present_rd <= present_mem[page];
  end

  always_ff @(posedge clk) begin
    if (do_fault) frame_mem[page] <= new_frame;
    if (cmd.lookup) pf_rd <= frame_mem[page];
  end

  // Sweep the present bits after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_wr) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  assign status.clear_last = (clear_addr == PAGE_BITS'(NUM_PAGES - 1));
  assign status.out_free   = !out_valid || m_tready;

  // Resolve the translation
  assign new_frame = next_free[PAGE_BITS-1:0];
  assign fault     = !hit_reg && !present_rd;
  assign do_fault  = cmd.commit && fault;

  always_comb begin
    if (hit_reg) begin
      frame = tlb_frame_rd;
    end else if (present_rd) begin
      frame = pf_rd;
    end else begin
      frame = new_frame;
    end
  end

  assign frame_wide = CW'(frame);
  assign phys_wide  = (frame_wide << OFFSET_BITS) | CW'(offset);

  // FIFO pointer, allocator and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_ptr          <= '0;
      next_free         <= '0;
      fault_counter     <= '0;
      hit_counter       <= '0;
      reference_counter <= '0;
    end else if (cmd.commit) begin
      if (fault) begin
        fifo_ptr <= (fifo_ptr == IDX_W'(TLB_ENTRIES - 1)) ? '0 : fifo_ptr + 1'b1;
        if (next_free < NFF_W'(NUM_PAGES)) next_free <= next_free + 1'b1;
        if (fault_counter != '1) fault_counter <= fault_counter + 1'b1;
      end
      if (hit_reg && (hit_counter != '1)) hit_counter <= hit_counter + 1'b1;
      if (reference_counter != '1) reference_counter <= reference_counter + 1'b1;
    end
  end

  // Output register; counters change only when a result is loaded
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_phys  <= phys_wide[tlbpt_pkg::PA_W-1:0];
      out_frame <= frame_wide[tlbpt_pkg::FRAME_OUT_W-1:0];
      out_hit   <= hit_reg;
      out_fault <= fault;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {reference_counter, hit_counter, fault_counter, out_frame, out_phys};
  assign m_tuser  = {out_fault, out_hit};

  // A page lives in at most one TLB slot
  a_single_match: assert property (@(posedge clk) disable iff (rst)
    cmd.select |-> $onehot0(match_reg))
    else $error("more than one TLB slot matches the page");

  // A result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || m_tready))
    else $error("output register overwritten");

  // Frames are never exhausted: each page faults only once
  a_frame_left: assert property (@(posedge clk) disable iff (rst)
    do_fault |-> (next_free < NFF_W'(NUM_PAGES)))
    else $error("fault with no free frame left");

  // A fault fills the slot under the FIFO pointer and moves the pointer
  a_fifo_fill: assert property (@(posedge clk) disable iff (rst)
    do_fault |=> (tlb_valid[$past(fifo_ptr)] && (fifo_ptr != $past(fifo_ptr))))
    else $error("TLB slot not filled on fault");

endmodule

// ===== rtl/tlb_page_table_translator.sv =====
// ----------------------------------------------------------------------------
// tlb_page_table_translator
// Virtual to physical address translation with a FIFO-replaced TLB backed by
// a page table that allocates frames on demand.
// ----------------------------------------------------------------------------
// Each address transaction goes from acceptance to a loaded result in steps:
// acceptance, the TLB tag compare and the registered page-table read, the
// selection of the matching slot and the read of its frame from the TLB
// frame memory, and the update of the tables and the load of the output
// register. The registered reads of the page table and the TLB frame memory
// keep these steps apart. A finished result waits in the output register; a
// new address is accepted while it waits, and the update step holds until the
// result has been taken. After reset the block clears the page-table present
// bits in a pass over all 2**PAGE_BITS entries (256 by default), during which
// s_tready stays low. The page is taken from the address bits above
// OFFSET_BITS; flags travel in m_tuser and the translation and running
// totals in m_tdata.
// ----------------------------------------------------------------------------
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF,
  parameter int PAGE_BITS   = tlbpt_pkg::PAGE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tlbpt_pkg::VA_W-1:0]         s_tdata,   // [15:0] virtual_address
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [15:0] physical_address, [23:16] frame_number, [55:24] fault_total,
  // [87:56] hit_total, [119:88] reference_total
  output logic [tlbpt_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic [tlbpt_pkg::OUT_TUSER_W-1:0]  m_tuser    // [0] tlb_hit, [1] page_fault
);

  tlbpt_pkg::tlbpt_cmd_t    cmd;
  tlbpt_pkg::tlbpt_status_t status;

  // Sequencer
  tlbpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Tables, allocator, counters and output register
  tlbpt_datapath #(
    .TLB_ENTRIES (TLB_ENTRIES),
    .OFFSET_BITS (OFFSET_BITS),
    .PAGE_BITS   (PAGE_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TLB and page-table address translator. A local
// model of the TLB, the page table and the running totals predicts every
// translation, and each result transaction is checked field by field against
// the oldest prediction. A short directed run covers the special cases, then
// random addresses mixing hits, table hits and faults under several idling
// phases.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TLB_SLOTS   = tlbpt_pkg::TLB_ENTRIES_DEF;
  localparam int OFF_W       = tlbpt_pkg::OFFSET_BITS_DEF;
  localparam int PAGE_W      = tlbpt_pkg::PAGE_BITS_DEF;
  localparam int NUM_PAGES   = 1 << PAGE_W;
  localparam int PHASE_ITEMS = 470;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 20;
  localparam int PRINT_LIMIT = 40;
  localparam int RECENT_KEEP = 12;

  typedef struct {
    logic [tlbpt_pkg::PA_W-1:0]        phys;
    logic [tlbpt_pkg::FRAME_OUT_W-1:0] frame;
    logic                              hit;
    logic                              fault;
    logic [tlbpt_pkg::COUNT_W-1:0]     fault_total;
    logic [tlbpt_pkg::COUNT_W-1:0]     hit_total;
    logic [tlbpt_pkg::COUNT_W-1:0]     ref_total;
  } xlate_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [tlbpt_pkg::VA_W-1:0]        s_tdata = '0;    // [15:0] virtual_address
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  // [15:0] physical_address, [23:16] frame_number, [55:24] fault_total,
  // [87:56] hit_total, [119:88] reference_total
  logic [tlbpt_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [tlbpt_pkg::OUT_TUSER_W-1:0] m_tuser;         // [0] tlb_hit, [1] page_fault

  tlb_page_table_translator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Model state: translation cache, page table, allocator and totals
  bit                            tlb_valid [TLB_SLOTS];
  bit [PAGE_W-1:0]               tlb_page  [TLB_SLOTS];
  bit [PAGE_W-1:0]               tlb_frame [TLB_SLOTS];
  bit                            page_present [NUM_PAGES];
  bit [PAGE_W-1:0]               page_frame   [NUM_PAGES];
  int                            fifo_ptr = 0;
  bit [PAGE_W:0]                 next_frame = '0;
  bit [tlbpt_pkg::COUNT_W-1:0]   fault_count = '0;
  bit [tlbpt_pkg::COUNT_W-1:0]   hit_count = '0;
  bit [tlbpt_pkg::COUNT_W-1:0]   ref_count = '0;

  // Stimulus and checking bookkeeping
  logic [tlbpt_pkg::VA_W-1:0]    addr_backlog [$];
  xlate_t                        due_translations [$];
  xlate_t                        want;
  logic [PAGE_W-1:0]             recent_pages [$];
  logic [PAGE_W-1:0]             seen_pages [$];
  bit                            page_issued [NUM_PAGES];
  int                            src_idle_pct = 0;
  int                            sink_stall_pct = 0;
  int                            error_count = 0;
  int                            quiet_cycles = 0;
  logic                          in_fire = 1'b0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic bit [tlbpt_pkg::COUNT_W-1:0] sat_inc(
    input bit [tlbpt_pkg::COUNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Translate one address and advance the model state
  function automatic xlate_t translate_address(input logic [tlbpt_pkg::VA_W-1:0] va);
    xlate_t            r;
    bit [PAGE_W-1:0]   page;
    bit [OFF_W-1:0]    offset;
    bit [PAGE_W-1:0]   frame;
    bit                found;
    page   = va[OFF_W +: PAGE_W];
    offset = va[OFF_W-1:0];
    frame  = '0;
    found  = 1'b0;
    r.fault = 1'b0;
    // lowest matching slot wins
    for (int k = 0; k < TLB_SLOTS; k++) begin
      if (!found && tlb_valid[k] && tlb_page[k] == page) begin
        found = 1'b1;
        frame = tlb_frame[k];
      end
    end
    if (found) begin
      hit_count = sat_inc(hit_count);
    end else begin
      if (!page_present[page]) begin
        // fault: allocate the next frame, record it, fill the FIFO slot
        r.fault = 1'b1;
        page_present[page]  = 1'b1;
        page_frame[page]    = next_frame[PAGE_W-1:0];
        tlb_valid[fifo_ptr] = 1'b1;
        tlb_page[fifo_ptr]  = page;
        tlb_frame[fifo_ptr] = next_frame[PAGE_W-1:0];
        fifo_ptr = (fifo_ptr + 1) % TLB_SLOTS;
        if (next_frame < NUM_PAGES) next_frame = next_frame + 1'b1;
        fault_count = sat_inc(fault_count);
      end
      frame = page_frame[page];
    end
    ref_count = sat_inc(ref_count);
    r.phys        = tlbpt_pkg::PA_W'((tlbpt_pkg::PA_W'(frame) << OFF_W)
                                     | tlbpt_pkg::PA_W'(offset));
    r.frame       = tlbpt_pkg::FRAME_OUT_W'(frame);
    r.hit         = found;
    r.fault_total = fault_count;
    r.hit_total   = hit_count;
    r.ref_total   = ref_count;
    return r;
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) $display("%0t ns: ERROR %s", $realtime, msg);
  endtask

  task automatic check_field(input string name,
                             input logic [tlbpt_pkg::COUNT_W-1:0] got,
                             input logic [tlbpt_pkg::COUNT_W-1:0] exp_val);
    if (got !== exp_val)
      report_error($sformatf("%s: got %h, expected %h", name, got, exp_val));
  endtask

  // Queue an address and remember its page for the random mix
  task automatic queue_address(input logic [tlbpt_pkg::VA_W-1:0] va);
    logic [PAGE_W-1:0] page;
    page = va[OFF_W +: PAGE_W];
    addr_backlog.push_back(va);
    recent_pages.push_back(page);
    if (recent_pages.size() > RECENT_KEEP) void'(recent_pages.pop_front());
    if (!page_issued[page]) begin
      page_issued[page] = 1'b1;
      seen_pages.push_back(page);
    end
  endtask

  // Hold until every queued address is sent and every result has returned
  task automatic wait_drained();
    while (addr_backlog.size() != 0 || due_translations.size() != 0 || s_tvalid)
      @(negedge clk);
    @(posedge clk);
  endtask

  // Driver: present addresses and toggle the result ready
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (!s_tvalid || in_fire) begin
        if (addr_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= addr_backlog.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor: check result transactions, then predict accepted addresses
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        if (due_translations.size() == 0) begin
          report_error($sformatf("result with no translation outstanding, tdata %h",
                                 m_tdata));
        end else begin
          want = due_translations.pop_front();
          check_field("physical_address", 32'(m_tdata[15:0]), 32'(want.phys));
          check_field("frame_number", 32'(m_tdata[23:16]), 32'(want.frame));
          check_field("tlb_hit", 32'(m_tuser[0]), 32'(want.hit));
          check_field("page_fault", 32'(m_tuser[1]), 32'(want.fault));
          check_field("fault_total", m_tdata[55:24], want.fault_total);
          check_field("hit_total", m_tdata[87:56], want.hit_total);
          check_field("reference_total", m_tdata[119:88], want.ref_total);
        end
      end
      if (s_tvalid && s_tready) due_translations.push_back(translate_address(s_tdata));
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    int               roll;
    logic [PAGE_W-1:0] page;

    // Directed: offset extremes, hits, FIFO wrap and a table-only hit
    queue_address(16'h0000);   // first fault, frame zero
    queue_address(16'h00FF);   // cache hit, top offset
    queue_address(16'hFFFF);   // top page faults
    queue_address(16'hFF00);   // cache hit, bottom offset
    for (int p = 1; p < 16; p++)
      // fill the cache, wrap the pointer
      queue_address(tlbpt_pkg::VA_W'((p << OFF_W) | (p * 17)));
    queue_address(16'h0080);   // page zero evicted: table hit, cache untouched
    queue_address(16'hFF55);   // still cached
    queue_address(16'hAAAA);
    queue_address(16'h5555);
    queue_address(16'h0001);   // table hit again

    repeat (7) @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < 4; ph++) begin
      wait_drained();
      case (ph)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 85; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 85; end
        default: begin src_idle_pct = 24; sink_stall_pct = 24; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // pause the sender once until every result is back
        if (ph == 1 && n == PHASE_ITEMS / 2) wait_drained();
        roll = $urandom_range(99);
        if (roll < 45) page = recent_pages[$urandom_range(recent_pages.size() - 1)];
        else if (roll < 75) page = seen_pages[$urandom_range(seen_pages.size() - 1)];
        else page = PAGE_W'($urandom_range(NUM_PAGES - 1));
        queue_address({page, OFF_W'($urandom_range((1 << OFF_W) - 1))});
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
